[rtl/dcm_pkg.sv]
`timescale 1ns / 1ps

package dcm_pkg;

	localparam int CMP_W = 12;
	localparam int PCT_W = 8;
	localparam int CNT_W = 16;
	localparam int RPM_W = 26;

	localparam logic signed [PCT_W-1:0] PCT_POS_MAX = 8'sd100;
	localparam logic signed [PCT_W-1:0] PCT_NEG_MAX = -8'sd100;
	localparam logic [CNT_W-1:0] EDGE_MAX = 16'hFFFF;
	localparam logic [RPM_W-1:0] RPM_MAX = 26'h3FF_FFFF;
	localparam logic [6:0] RPM_SCALE = 7'd100;

	// input beat kinds carried on tuser
	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_EDGE   = 2'd1,
		OP_TARGET = 2'd2
	} op_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_ACCEL = 2'd0,
		REG_DECEL = 2'd1,
		REG_COAST = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] accel_step;
		logic [7:0] decel_step;
		logic       coast_at_zero;
	} ramp_cfg_t;

	typedef struct packed {
		logic [RPM_W-1:0]        speed_rpm;
		logic signed [PCT_W-1:0] drive_percent;
		logic [CMP_W-1:0]        compare_b;
		logic [CMP_W-1:0]        compare_a;
	} result_t;

endpackage

[rtl/dc_motor_ramp_pwm_and_rpm_unit.sv]
`timescale 1ns / 1ps
// each accepted result is registered and reaches m_tvalid behind any older result still waiting
// one input beat per cycle unless skid is full; state update and result in one registered pass
// a two-entry output stage (result register plus skid) keeps s_tready up while one result waits
// reset (arst_n low, asynchronous): power, target, brake, counters and rpm window clear to zero,
// accel_step and decel_step return to 1 and coast_at_zero to 1, no result beat is pending

module dc_motor_ramp_pwm_and_rpm_unit #(
	parameter int PWM_PERIOD        = 2400,
	parameter int RPM_WINDOW        = 10,
	parameter int RAMP_PERIOD_TICKS = 2,
	parameter int RPM_PERIOD_TICKS  = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] target_percent, [8] brake_request, rest zero
	input  logic [1:0]  s_tuser,   // [1:0] op
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [11:0] compare_a, [23:12] compare_b,
	                               // [31:24] drive_percent, [57:32] speed_rpm, rest zero
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	// configuration registers
	dcm_pkg::ramp_cfg_t cfg_q;

	// input beat decode
	logic        accept;
	logic        is_tick, is_edge, is_tgt;
	dcm_pkg::op_t op;

	// per-beat result pieces
	logic [dcm_pkg::CMP_W-1:0]        cmp_a, cmp_b;
	logic signed [dcm_pkg::PCT_W-1:0] drive;
	logic [dcm_pkg::RPM_W-1:0]        rpm;
	dcm_pkg::result_t                 res;
	dcm_pkg::result_t                 res_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.accel_step    <= 8'd1;
			cfg_q.decel_step    <= 8'd1;
			cfg_q.coast_at_zero <= 1'b1;
		end else if (cfg_valid) begin
			case (dcm_pkg::reg_idx_t'(cfg_index))
				dcm_pkg::REG_ACCEL: cfg_q.accel_step    <= cfg_data;
				dcm_pkg::REG_DECEL: cfg_q.decel_step    <= cfg_data;
				dcm_pkg::REG_COAST: cfg_q.coast_at_zero <= cfg_data[0];
				default: ;  // unused index, write dropped
			endcase
		end
	end

	assign accept = s_tvalid && s_tready;
	assign op     = dcm_pkg::op_t'(s_tuser);

	// op 3 touches no state; its result just repeats the held outputs
	always_comb begin
		is_tick = 1'b0;
		is_edge = 1'b0;
		is_tgt  = 1'b0;
		case (op)
			dcm_pkg::OP_TICK:   is_tick = accept;
			dcm_pkg::OP_EDGE:   is_edge = accept;
			dcm_pkg::OP_TARGET: is_tgt  = accept;
			default: ;
		endcase
	end

	// slew-limited power and bridge compare values, serviced on ramp ticks
	dcm_ramp #(
		.PWM_PERIOD        (PWM_PERIOD),
		.RAMP_PERIOD_TICKS (RAMP_PERIOD_TICKS)
	) u_ramp (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (is_tick),
		.tgt_wr  (is_tgt),
		.tgt_pct ($signed(s_tdata[7:0])),
		.brk_req (s_tdata[8]),
		.cfg     (cfg_q),
		.cmp_a   (cmp_a),
		.cmp_b   (cmp_b),
		.drive   (drive)
	);

	// encoder edge counting and windowed speed, serviced on speed ticks
	dcm_speed #(
		.RPM_WINDOW       (RPM_WINDOW),
		.RPM_PERIOD_TICKS (RPM_PERIOD_TICKS)
	) u_speed (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (is_tick),
		.edge_in (is_edge),
		.rpm     (rpm)
	);

	always_comb begin
		res.compare_a     = cmp_a;
		res.compare_b     = cmp_b;
		res.drive_percent = drive;
		res.speed_rpm     = rpm;
	end

	// result register with skid: one waiting result does not stall the input side
	dcm_out_skid u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_data  (res),
		.push_ready (s_tready),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (res_out)
	);

	assign m_tdata = {6'b0, res_out.speed_rpm, res_out.drive_percent,
	                  res_out.compare_b, res_out.compare_a};

	// after every accepted beat m_tvalid is high on the next cycle, possibly for an older result
	a_accept_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted beat produced no result beat");

	// input side only stalls while a result is waiting in the skid entry
	a_stall_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no pending result");

	// applied power never leaves the saturated target range
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[31:24]) <= 8'sd100
		              && $signed(m_tdata[31:24]) >= -8'sd100))
		else $error("drive_percent out of range");

endmodule

[rtl/dcm_ramp.sv]
`timescale 1ns / 1ps

module dcm_ramp #(
	parameter int PWM_PERIOD        = 2400,
	parameter int RAMP_PERIOD_TICKS = 2
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                tick,
	input  logic                                tgt_wr,
	input  logic signed [dcm_pkg::PCT_W-1:0]    tgt_pct,
	input  logic                                brk_req,
	input  dcm_pkg::ramp_cfg_t                  cfg,
	output logic [dcm_pkg::CMP_W-1:0]           cmp_a,
	output logic [dcm_pkg::CMP_W-1:0]           cmp_b,
	output logic signed [dcm_pkg::PCT_W-1:0]    drive
);

	localparam int PH_W = (RAMP_PERIOD_TICKS > 1) ? $clog2(RAMP_PERIOD_TICKS) : 1;
	localparam logic [PH_W-1:0] PH_LAST = PH_W'(RAMP_PERIOD_TICKS - 1);
	localparam logic [dcm_pkg::CMP_W-1:0] FULL = dcm_pkg::CMP_W'(PWM_PERIOD);

	logic signed [dcm_pkg::PCT_W-1:0] drive_q, target_q;
	logic                             brake_q;
	logic [PH_W-1:0]                  phase_q;
	logic [dcm_pkg::CMP_W-1:0]        cmp_a_q, cmp_b_q;

	// compare value for each power magnitude: period - period*p/100
	logic [dcm_pkg::CMP_W-1:0] cmp_tbl [0:100];
	for (genvar gi = 0; gi <= 100; gi++) begin : g_tbl
		localparam int unsigned CmpVal = PWM_PERIOD - (PWM_PERIOD * gi) / 100;
		assign cmp_tbl[gi] = CmpVal[dcm_pkg::CMP_W-1:0];
	end

	logic                             ramp_fire;
	logic signed [8:0]                diff;
	logic [8:0]                       diff_mag;
	logic signed [dcm_pkg::PCT_W-1:0] ramped, ramped_mag, tgt_sat;
	logic signed [dcm_pkg::PCT_W-1:0] drive_nxt, target_nxt;
	logic [dcm_pkg::CMP_W-1:0]        new_a, new_b;

	assign ramp_fire = tick && (phase_q == '0);
	assign diff      = 9'(target_q) - 9'(drive_q);
	assign diff_mag  = diff[8] ? 9'(-diff) : 9'(diff);

	always_comb begin
		if (diff > 9'sd0) begin
			if ({1'b0, cfg.accel_step} > diff_mag) ramped = target_q;
			else ramped = drive_q + $signed(cfg.accel_step);
		end else if (diff < 9'sd0) begin
			if ({1'b0, cfg.decel_step} > diff_mag) ramped = target_q;
			else ramped = drive_q - $signed(cfg.decel_step);
		end else begin
			ramped = drive_q;
		end
	end

	assign ramped_mag = ramped[dcm_pkg::PCT_W-1] ? -ramped : ramped;

	always_comb begin
		if (brake_q) begin
			new_a = FULL;
			new_b = FULL;
		end else if (ramped > 8'sd0) begin
			new_a = FULL;
			new_b = cmp_tbl[ramped_mag[6:0]];
		end else if (ramped < 8'sd0) begin
			new_a = cmp_tbl[ramped_mag[6:0]];
			new_b = FULL;
		end else if (cfg.coast_at_zero) begin
			new_a = '0;
			new_b = '0;
		end else begin
			new_a = FULL;
			new_b = FULL;
		end
	end

	always_comb begin
		if (tgt_pct > dcm_pkg::PCT_POS_MAX) tgt_sat = dcm_pkg::PCT_POS_MAX;
		else if (tgt_pct < dcm_pkg::PCT_NEG_MAX) tgt_sat = dcm_pkg::PCT_NEG_MAX;
		else tgt_sat = tgt_pct;
	end

	always_comb begin
		drive_nxt  = drive_q;
		target_nxt = target_q;
		if (ramp_fire) begin
			drive_nxt = brake_q ? '0 : ramped;
			if (brake_q) target_nxt = '0;
		end
		if (tgt_wr) target_nxt = tgt_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_q  <= '0;
			target_q <= '0;
			brake_q  <= 1'b0;
			phase_q  <= '0;
			cmp_a_q  <= '0;
			cmp_b_q  <= '0;
		end else begin
			drive_q  <= drive_nxt;
			target_q <= target_nxt;
			if (tgt_wr) brake_q <= brk_req;
			if (tick) phase_q <= (phase_q == PH_LAST) ? '0 : phase_q + 1'b1;
			if (ramp_fire) begin
				cmp_a_q <= new_a;
				cmp_b_q <= new_b;
			end
		end
	end

	assign cmp_a = ramp_fire ? new_a : cmp_a_q;
	assign cmp_b = ramp_fire ? new_b : cmp_b_q;
	assign drive = drive_nxt;

endmodule

[rtl/dcm_speed.sv]
`timescale 1ns / 1ps

module dcm_speed #(
	parameter int RPM_WINDOW       = 10,
	parameter int RPM_PERIOD_TICKS = 10
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      tick,
	input  logic                      edge_in,
	output logic [dcm_pkg::RPM_W-1:0] rpm
);

	localparam int PH_W   = (RPM_PERIOD_TICKS > 1) ? $clog2(RPM_PERIOD_TICKS) : 1;
	localparam logic [PH_W-1:0] PH_LAST = PH_W'(RPM_PERIOD_TICKS - 1);
	localparam int SUM_W  = $clog2(RPM_WINDOW * 65535 + 1);
	localparam int PROD_W = (SUM_W + 7 > dcm_pkg::RPM_W) ? SUM_W + 7 : dcm_pkg::RPM_W;

	logic [dcm_pkg::CNT_W-1:0] edge_cnt_q;
	// window as a shift line: the oldest interval drops out of the last tap
	logic [dcm_pkg::CNT_W-1:0] win_q [RPM_WINDOW];
	logic [SUM_W-1:0]          sum_q;
	logic [PH_W-1:0]           phase_q;
	logic [dcm_pkg::RPM_W-1:0] rpm_q;

	logic              measure;
	logic [SUM_W-1:0]  sum_nxt;
	logic [PROD_W-1:0] prod;
	logic [dcm_pkg::RPM_W-1:0] rpm_new;

	assign measure = tick && (phase_q == '0);
	assign sum_nxt = (sum_q + SUM_W'(edge_cnt_q)) - SUM_W'(win_q[RPM_WINDOW-1]);
	assign prod    = PROD_W'(sum_nxt) * PROD_W'(dcm_pkg::RPM_SCALE);
	assign rpm_new = (prod > PROD_W'(dcm_pkg::RPM_MAX)) ? dcm_pkg::RPM_MAX
	                                                    : prod[dcm_pkg::RPM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_cnt_q <= '0;
			sum_q      <= '0;
			phase_q    <= '0;
			rpm_q      <= '0;
			for (int i = 0; i < RPM_WINDOW; i++) win_q[i] <= '0;
		end else begin
			if (tick) phase_q <= (phase_q == PH_LAST) ? '0 : phase_q + 1'b1;
			if (measure) begin
				for (int i = RPM_WINDOW - 1; i > 0; i--) win_q[i] <= win_q[i-1];
				win_q[0]   <= edge_cnt_q;
				sum_q      <= sum_nxt;
				rpm_q      <= rpm_new;
				edge_cnt_q <= '0;
			end else if (edge_in && (edge_cnt_q != dcm_pkg::EDGE_MAX)) begin
				edge_cnt_q <= edge_cnt_q + 1'b1;
			end
		end
	end

	assign rpm = measure ? rpm_new : rpm_q;

endmodule

[rtl/dcm_out_skid.sv]
`timescale 1ns / 1ps

module dcm_out_skid (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dcm_pkg::result_t  push_data,
	output logic              push_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output dcm_pkg::result_t  out_data
);

	logic             out_v_q, skid_v_q;
	dcm_pkg::result_t out_d_q, skid_d_q;
	logic             take;

	assign take = out_v_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (push) begin
				if (!out_v_q || take) out_v_q <= 1'b1;
				else skid_v_q <= 1'b1;
			end else if (take) begin
				if (skid_v_q) skid_v_q <= 1'b0;
				else out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (!out_v_q || take) out_d_q <= push_data;
			else skid_d_q <= push_data;
		end else if (take && skid_v_q) begin
			out_d_q <= skid_d_q;
		end
	end

	assign push_ready = !skid_v_q;
	assign out_valid  = out_v_q;
	assign out_data   = out_d_q;

endmodule

[verif/dc_motor_ramp_pwm_and_rpm_unit_tb.sv]
`timescale 1ns / 1ps

module dc_motor_ramp_pwm_and_rpm_unit_tb;

	// block configuration used for both the instance and the prediction
	localparam int PWM_FULL     = 2400;
	localparam int WINDOW_LEN   = 10;
	localparam int RAMP_TICKS   = 2;
	localparam int SPEED_TICKS  = 10;
	localparam int STALL_LIMIT  = 5000;
	localparam int TAIL_CYCLES  = 10;
	localparam int EDGE_BURST   = 20;

	// op code 3 has no meaning in the block and is simply ignored
	localparam logic [1:0] OP_SPARE = 2'd3;

	typedef struct {
		logic [1:0] op;
		logic [7:0] target;
		logic       brake;
		bit         drain_first;   // hold this beat until all results are back
	} motor_beat_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata   = '0;
	logic [1:0]  s_tuser   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [63:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_data  = '0;

	dc_motor_ramp_pwm_and_rpm_unit #(
		.PWM_PERIOD       (PWM_FULL),
		.RPM_WINDOW       (WINDOW_LEN),
		.RAMP_PERIOD_TICKS(RAMP_TICKS),
		.RPM_PERIOD_TICKS (SPEED_TICKS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// 20 ns period
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// beats waiting to be driven and outputs waiting to come back
	motor_beat_t      pending_beats[$];
	dcm_pkg::result_t expected_outputs[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	logic in_taken = 1'b0;
	int fail_count = 0;

	// run statistics for the closing summary
	int beats_sent = 0;
	int outputs_checked = 0;
	int ticks_sent = 0;
	int brakes_sent = 0;
	int clamped_targets = 0;
	int spare_ops = 0;
	int config_writes = 0;
	int edge_peak = 0;

	// predicted motor channel state
	logic [7:0]                       accel_step;
	logic [7:0]                       decel_step;
	logic                             coast_at_zero;
	logic signed [dcm_pkg::PCT_W-1:0] drive_level;
	logic signed [dcm_pkg::PCT_W-1:0] target_level;
	logic                             brake_flag;
	logic [dcm_pkg::CNT_W-1:0]        edge_count;
	logic [dcm_pkg::CNT_W-1:0]        count_window[WINDOW_LEN];
	logic [19:0]                      window_sum;
	int                               window_pos;
	int                               ramp_phase;
	int                               speed_phase;
	logic [dcm_pkg::CMP_W-1:0]        held_a;
	logic [dcm_pkg::CMP_W-1:0]        held_b;
	logic [dcm_pkg::RPM_W-1:0]        held_rpm;

	// state after reset, registers at their reset values
	initial begin
		accel_step = 8'd1;
		decel_step = 8'd1;
		coast_at_zero = 1'b1;
		drive_level = '0;
		target_level = '0;
		brake_flag = 1'b0;
		edge_count = '0;
		foreach (count_window[i])
			count_window[i] = '0;
		window_sum = '0;
		window_pos = 0;
		ramp_phase = 0;
		speed_phase = 0;
		held_a = '0;
		held_b = '0;
		held_rpm = '0;
	end

	// advance the channel by one beat and return the outputs it shows
	function automatic dcm_pkg::result_t predict_motor_outputs(motor_beat_t b);
		int lvl;
		int tgt;
		int diff;
		longint rpm;
		dcm_pkg::result_t r;
		case (b.op)
			dcm_pkg::OP_TICK: begin
				if (ramp_phase == 0) begin
					// slew toward the target, snapping when within one step
					lvl = int'(drive_level);
					tgt = int'(target_level);
					diff = tgt - lvl;
					if (diff > 0) begin
						if (int'(accel_step) > diff)
							lvl = tgt;
						else
							lvl = lvl + int'(accel_step);
					end else if (diff < 0) begin
						if (int'(decel_step) > -diff)
							lvl = tgt;
						else
							lvl = lvl - int'(decel_step);
					end
					if (brake_flag) begin
						// brake clears both the target and the applied power
						lvl = 0;
						target_level = '0;
						held_a = dcm_pkg::CMP_W'(PWM_FULL);
						held_b = dcm_pkg::CMP_W'(PWM_FULL);
					end else if (lvl > 0) begin
						held_a = dcm_pkg::CMP_W'(PWM_FULL);
						held_b = dcm_pkg::CMP_W'(PWM_FULL - PWM_FULL * lvl / 100);
					end else if (lvl < 0) begin
						held_a = dcm_pkg::CMP_W'(PWM_FULL - PWM_FULL * (-lvl) / 100);
						held_b = dcm_pkg::CMP_W'(PWM_FULL);
					end else if (coast_at_zero) begin
						held_a = '0;
						held_b = '0;
					end else begin
						held_a = dcm_pkg::CMP_W'(PWM_FULL);
						held_b = dcm_pkg::CMP_W'(PWM_FULL);
					end
					drive_level = dcm_pkg::PCT_W'(lvl);
				end
				ramp_phase = (ramp_phase + 1) % RAMP_TICKS;
				if (speed_phase == 0) begin
					// running window sum of edge counts, one entry per interval
					window_sum = window_sum - count_window[window_pos];
					count_window[window_pos] = edge_count;
					window_sum = window_sum + edge_count;
					edge_count = '0;
					window_pos = (window_pos + 1) % WINDOW_LEN;
					rpm = longint'(window_sum) * 100;
					held_rpm = (rpm > longint'(dcm_pkg::RPM_MAX)) ? dcm_pkg::RPM_MAX
					                                              : dcm_pkg::RPM_W'(rpm);
				end
				speed_phase = (speed_phase + 1) % SPEED_TICKS;
			end
			dcm_pkg::OP_EDGE: begin
				if (edge_count < dcm_pkg::EDGE_MAX)
					edge_count = edge_count + 1'b1;
				if (int'(edge_count) > edge_peak)
					edge_peak = int'(edge_count);
			end
			dcm_pkg::OP_TARGET: begin
				// out of range targets clamp to full power either way
				tgt = int'($signed(b.target));
				if (tgt > int'(dcm_pkg::PCT_POS_MAX))
					tgt = int'(dcm_pkg::PCT_POS_MAX);
				if (tgt < int'(dcm_pkg::PCT_NEG_MAX))
					tgt = int'(dcm_pkg::PCT_NEG_MAX);
				target_level = dcm_pkg::PCT_W'(tgt);
				brake_flag = b.brake;
			end
			default: ;
		endcase
		r.compare_a = held_a;
		r.compare_b = held_b;
		r.drive_percent = drive_level;
		r.speed_rpm = held_rpm;
		return r;
	endfunction

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// driver: input and ready changes land on the falling edge
	always @(negedge clk) begin : beat_driver
		motor_beat_t b;
		if (arst_n) begin
			if (!s_tvalid || in_taken) begin
				if (pending_beats.size() != 0
				    && !(pending_beats[0].drain_first && expected_outputs.size() != 0)
				    && $urandom_range(0, 99) >= send_idle_pct) begin
					b = pending_beats.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {7'd0, b.brake, b.target};
					s_tuser <= b.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// monitor: everything sampled on the rising edge
	always @(posedge clk) begin : beat_monitor
		dcm_pkg::result_t got;
		dcm_pkg::result_t want;
		motor_beat_t b;
		if (arst_n) begin
			// a result beat always belongs to an earlier input beat
			if (m_tvalid && m_tready) begin
				got = dcm_pkg::result_t'(m_tdata[57:0]);
				if (expected_outputs.size() == 0) begin
					$error("result beat with no expected outputs pending");
					fail_count++;
				end else begin
					want = expected_outputs.pop_front();
					check_field("compare_a", want.compare_a, got.compare_a);
					check_field("compare_b", want.compare_b, got.compare_b);
					check_field("drive_percent", want.drive_percent, got.drive_percent);
					check_field("speed_rpm", want.speed_rpm, got.speed_rpm);
					check_field("tdata padding", 0, m_tdata[63:58]);
					outputs_checked++;
				end
			end
			if (s_tvalid && s_tready) begin
				b.op = s_tuser;
				b.target = s_tdata[7:0];
				b.brake = s_tdata[8];
				b.drain_first = 1'b0;
				expected_outputs.push_back(predict_motor_outputs(b));
				beats_sent++;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					dcm_pkg::REG_ACCEL: accel_step = cfg_data;
					dcm_pkg::REG_DECEL: decel_step = cfg_data;
					dcm_pkg::REG_COAST: coast_at_zero = cfg_data[0];
					default: ;
				endcase
				config_writes++;
			end
			in_taken <= s_tvalid && s_tready;
		end
	end

	// watchdog on cycles without any beat on any channel
	int stall_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no beat for %0d cycles, %0d outputs outstanding",
				         stall_cycles, expected_outputs.size());
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	task automatic queue_beat(input logic [1:0] op, input logic [7:0] target,
	                          input logic brake, input bit drain_first = 1'b0);
		motor_beat_t b;
		b.op = op;
		b.target = target;
		b.brake = brake;
		b.drain_first = drain_first;
		if (op == dcm_pkg::OP_TICK)
			ticks_sent++;
		if (op == OP_SPARE)
			spare_ops++;
		if (op == dcm_pkg::OP_TARGET && brake)
			brakes_sent++;
		if (op == dcm_pkg::OP_TARGET && ($signed(target) > dcm_pkg::PCT_POS_MAX
		                                 || $signed(target) < dcm_pkg::PCT_NEG_MAX))
			clamped_targets++;
		pending_beats.push_back(b);
	endtask

	// block is idle once nothing is queued, driven or awaited
	task automatic wait_for_drain();
		do
			@(posedge clk);
		while (!(pending_beats.size() == 0 && !s_tvalid && expected_outputs.size() == 0));
		repeat (2) @(posedge clk);
	endtask

	task automatic write_register(input dcm_pkg::reg_idx_t idx, input logic [7:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_ramp(input logic [7:0] accel, input logic [7:0] decel, input logic coast);
		wait_for_drain();
		write_register(dcm_pkg::REG_ACCEL, accel);
		write_register(dcm_pkg::REG_DECEL, decel);
		// upper data bits are don't-care for the coast flag
		write_register(dcm_pkg::REG_COAST, {7'($urandom_range(0, 127)), coast});
	endtask

	// mostly ticks and encoder edges with target writes mixed in,
	// a sprinkle of brakes, out of range targets and spare op codes
	task automatic queue_motor_traffic(input int count);
		int made;
		int pick;
		logic [7:0] tgt;
		made = 0;
		while (made < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 2) begin
				queue_beat(OP_SPARE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end else begin
				if (pick < 10) begin
					if ($urandom_range(0, 4) == 0)
						tgt = 8'($urandom_range(0, 255));
					else
						tgt = 8'($urandom_range(0, 200) - 100);
					queue_beat(dcm_pkg::OP_TARGET, tgt, ($urandom_range(0, 9) == 0),
					           ($urandom_range(0, 99) == 0));
				end else if (pick < 50) begin
					queue_beat(dcm_pkg::OP_TICK, 8'($urandom_range(0, 255)),
					           1'($urandom_range(0, 1)));
				end else begin
					queue_beat(dcm_pkg::OP_EDGE, 8'($urandom_range(0, 255)),
					           1'($urandom_range(0, 1)));
				end
				made++;
			end
		end
	endtask

	initial begin : stimulus
		int seg;
		int k;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed, reset config: spare op before the first tick shows zeros,
		// clamped targets in both directions, unit steps
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_beat(OP_SPARE, 8'hFF, 1'b1);
		queue_beat(dcm_pkg::OP_EDGE, 8'h00, 1'b0);
		queue_beat(dcm_pkg::OP_EDGE, 8'h00, 1'b0);
		queue_beat(dcm_pkg::OP_EDGE, 8'h00, 1'b0);
		queue_beat(dcm_pkg::OP_TARGET, 8'sd127, 1'b0);
		queue_beat(dcm_pkg::OP_TICK, 8'h00, 1'b0);
		queue_beat(dcm_pkg::OP_TICK, 8'h00, 1'b0);
		queue_beat(dcm_pkg::OP_TICK, 8'h00, 1'b0);
		queue_beat(dcm_pkg::OP_TARGET, 8'h80, 1'b0);
		queue_beat(dcm_pkg::OP_TICK, 8'h00, 1'b0);
		queue_beat(dcm_pkg::OP_TICK, 8'h00, 1'b0);

		// directed, big steps and brake at zero: snap to target, zero power
		// braking, brake flag holding, full power both ways
		set_ramp(8'd200, 8'd200, 1'b0);
		queue_beat(dcm_pkg::OP_TICK, 8'h00, 1'b0);
		queue_beat(dcm_pkg::OP_TICK, 8'h00, 1'b0);
		queue_beat(dcm_pkg::OP_TARGET, 8'h00, 1'b0);
		queue_beat(dcm_pkg::OP_TICK, 8'h00, 1'b0);
		queue_beat(dcm_pkg::OP_TICK, 8'h00, 1'b0);
		queue_beat(dcm_pkg::OP_TARGET, 8'h55, 1'b1);
		queue_beat(dcm_pkg::OP_TICK, 8'h00, 1'b0);
		queue_beat(dcm_pkg::OP_TICK, 8'h00, 1'b0);
		queue_beat(dcm_pkg::OP_TICK, 8'h00, 1'b0);
		queue_beat(dcm_pkg::OP_TARGET, 8'sd100, 1'b0);
		queue_beat(dcm_pkg::OP_TICK, 8'h00, 1'b0);
		queue_beat(dcm_pkg::OP_TICK, 8'h00, 1'b0);
		queue_beat(dcm_pkg::OP_TARGET, 8'h9C, 1'b0);
		queue_beat(dcm_pkg::OP_TICK, 8'h00, 1'b0);
		queue_beat(OP_SPARE, 8'h2A, 1'b0);

		// random part: three idle profiles, each across three ramp settings
		for (seg = 0; seg < 3; seg++) begin
			for (k = 0; k < 3; k++) begin
				case (seg * 3 + k)
					0: set_ramp(8'd0, 8'd0, 1'b1);
					1: set_ramp(8'd200, 8'd0, 1'b0);
					2: set_ramp(8'd0, 8'd200, 1'b1);
					3: set_ramp(8'd1, 8'd1, 1'b0);
					default: set_ramp(8'($urandom_range(0, 200)), 8'($urandom_range(0, 200)),
					                  1'($urandom_range(0, 1)));
				endcase
				case (seg)
					0: begin
						send_idle_pct = 12;
						recv_idle_pct = 73;
					end
					1: begin
						send_idle_pct = 73;
						recv_idle_pct = 12;
					end
					default: begin
						send_idle_pct = 0;
						recv_idle_pct = 0;
					end
				endcase
				// sender waits for the pipe to empty at the start of each setting
				queue_beat(dcm_pkg::OP_TARGET, 8'($urandom_range(0, 200) - 100), 1'b0, 1'b1);
				queue_motor_traffic(120);
			end
		end

		// a dense burst of edges in one interval, then enough ticks to bring it into the window
		set_ramp(8'($urandom_range(1, 200)), 8'($urandom_range(1, 200)), 1'b1);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_beat(dcm_pkg::OP_TICK, 8'h00, 1'b0);
		for (k = 0; k < EDGE_BURST; k++)
			queue_beat(dcm_pkg::OP_EDGE, 8'h00, 1'b0);
		for (k = 0; k < SPEED_TICKS; k++)
			queue_beat(dcm_pkg::OP_TICK, 8'h00, 1'b0);

		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_outputs.size() != 0) begin
			$error("%0d expected outputs never arrived", expected_outputs.size());
			fail_count++;
		end

		$display("covered %0d beats (%0d ticks, %0d brake writes, %0d clamped targets, %0d spare)",
		         beats_sent, ticks_sent, brakes_sent, clamped_targets, spare_ops);
		$display("checked %0d result beats over %0d register writes, peak edge count %0d",
		         outputs_checked, config_writes, edge_peak);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[dc_motor_ramp_pwm_and_rpm_unit.f]
rtl/dcm_pkg.sv
rtl/dcm_ramp.sv
rtl/dcm_speed.sv
rtl/dcm_out_skid.sv
rtl/dc_motor_ramp_pwm_and_rpm_unit.sv
verif/dc_motor_ramp_pwm_and_rpm_unit_tb.sv
